/* design/lbqc_pkg.sv */
// lbqc_pkg: shared types, character codes and the separator test for the
// line bracket and quote checker. No dependencies.

package lbqc_pkg;

	localparam logic [7:0] CH_LSQUARE = 8'h5B; // '['
	localparam logic [7:0] CH_RSQUARE = 8'h5D; // ']'
	localparam logic [7:0] CH_LBRACE  = 8'h7B; // '{'
	localparam logic [7:0] CH_RBRACE  = 8'h7D; // '}'
	localparam logic [7:0] CH_DOLLAR  = 8'h24; // '$'
	localparam logic [7:0] CH_QUOTE   = 8'h22; // '"'
	localparam logic [7:0] CH_COMMA   = 8'h2C; // ','
	localparam logic [7:0] CH_PLUS    = 8'h2B; // '+'
	localparam logic [7:0] CH_MINUS   = 8'h2D; // '-'
	localparam logic [7:0] CH_STAR    = 8'h2A; // '*'
	localparam logic [7:0] CH_SLASH   = 8'h2F; // '/'
	localparam logic [7:0] CH_LESS    = 8'h3C; // '<'
	localparam logic [7:0] CH_GREATER = 8'h3E; // '>'
	localparam logic [7:0] CH_LPAREN  = 8'h28; // '('
	localparam logic [7:0] CH_RPAREN  = 8'h29; // ')'
	localparam logic [7:0] CH_PIPE    = 8'h7C; // '|'
	localparam logic [7:0] CH_AMP     = 8'h26; // '&'

	typedef enum logic [2:0] {
		ERR_OK          = 3'd0,
		ERR_MISS_RSQ    = 3'd1,
		ERR_MISS_LSQ    = 3'd2,
		ERR_MISS_RBRACE = 3'd3,
		ERR_MISS_LBRACE = 3'd4,
		ERR_MISS_DOLLAR = 3'd5,
		ERR_ODD_QUOTES  = 3'd6,
		ERR_MISS_SIGN   = 3'd7
	} err_code_t;

	// per-line tracking state, all zero at line start
	typedef struct packed {
		logic       square_open;
		logic       square_seen_since;
		logic       brace_open;
		logic       brace_seen_since;
		logic       dollar_seen_since;
		logic       quote_parity;
		logic       fail_sq_open;
		logic       fail_sq_miss;
		logic       fail_br_open;
		logic       fail_br_miss;
		logic       fail_dol_miss;
		logic       fail_sign;
		logic [7:0] prev_char;
		logic       prev_closing_quote;
	} line_state_t;

	function automatic logic is_separator(input logic [7:0] c);
		return (c == CH_COMMA) || (c == CH_PLUS) || (c == CH_MINUS) ||
			(c == CH_STAR) || (c == CH_SLASH) || (c == CH_LESS) ||
			(c == CH_GREATER) || (c == CH_LPAREN) || (c == CH_RPAREN) ||
			(c == CH_PIPE) || (c == CH_AMP);
	endfunction

endpackage

/* design/lbqc_step.sv */
// lbqc_step: next-state and error-code logic for one character.
// Depends on lbqc_pkg.

module lbqc_step (
	input  lbqc_pkg::line_state_t cur,
	input  logic [7:0]            ch,
	input  logic                  last,
	output lbqc_pkg::line_state_t nxt,
	output lbqc_pkg::err_code_t   code
);

	lbqc_pkg::line_state_t upd;
	logic                  is_quote;

	always_comb begin
		upd      = cur;
		is_quote = (ch == lbqc_pkg::CH_QUOTE);

		// a non-final character after '}' or a closing quote must be a separator
		if (!last && (cur.prev_char == lbqc_pkg::CH_RBRACE || cur.prev_closing_quote) &&
			!lbqc_pkg::is_separator(ch)) begin
			upd.fail_sign = 1'b1;
		end

		if (ch == lbqc_pkg::CH_RSQUARE) begin
			upd.square_open       = 1'b0;
			upd.fail_sq_miss      = cur.fail_sq_miss | ~cur.square_seen_since;
			upd.square_seen_since = 1'b0;
		end else if (ch == lbqc_pkg::CH_LSQUARE) begin
			upd.fail_sq_open      = cur.fail_sq_open | cur.square_open;
			upd.square_open       = 1'b1;
			upd.square_seen_since = 1'b1;
		end

		if (ch == lbqc_pkg::CH_RBRACE) begin
			upd.brace_open        = 1'b0;
			upd.fail_br_miss      = cur.fail_br_miss | ~cur.brace_seen_since;
			upd.brace_seen_since  = 1'b0;
			upd.fail_dol_miss     = cur.fail_dol_miss | ~cur.dollar_seen_since;
			upd.dollar_seen_since = 1'b0;
		end else if (ch == lbqc_pkg::CH_LBRACE) begin
			upd.fail_br_open     = cur.fail_br_open | cur.brace_open;
			upd.brace_open       = 1'b1;
			upd.brace_seen_since = 1'b1;
		end else if (ch == lbqc_pkg::CH_DOLLAR) begin
			upd.dollar_seen_since = 1'b1;
		end

		upd.quote_parity       = cur.quote_parity ^ is_quote;
		upd.prev_closing_quote = is_quote & ~upd.quote_parity;
		upd.prev_char          = ch;

		priority if (upd.fail_sq_open || upd.square_open) begin
			code = lbqc_pkg::ERR_MISS_RSQ;
		end else if (upd.fail_sq_miss) begin
			code = lbqc_pkg::ERR_MISS_LSQ;
		end else if (upd.fail_br_open || upd.brace_open) begin
			code = lbqc_pkg::ERR_MISS_RBRACE;
		end else if (upd.fail_br_miss) begin
			code = lbqc_pkg::ERR_MISS_LBRACE;
		end else if (upd.fail_dol_miss) begin
			code = lbqc_pkg::ERR_MISS_DOLLAR;
		end else if (upd.quote_parity) begin
			code = lbqc_pkg::ERR_ODD_QUOTES;
		end else if (upd.fail_sign) begin
			code = lbqc_pkg::ERR_MISS_SIGN;
		end else begin
			code = lbqc_pkg::ERR_OK;
		end

		// the line ends here: start the next one clean
		nxt = last ? '0 : upd;
	end

endmodule

/* design/line_bracket_quote_checker_core.sv */
// line_bracket_quote_checker_core: top level of the line bracket and quote checker.
// Depends on lbqc_pkg and lbqc_step.

// Characters of a text line arrive one per transaction on the input channel, with
// last marking the line's final character. Each character is taken into an input
// register; from there the step logic updates the per-line tracking state, and
// for the final character writes one error code into the output register, where it
// waits for the output handshake while further characters keep flowing. The block
// takes one character per cycle while not stalled; a line's code passes through the
// input register and then the output register. Only a pending code that is not taken
// stalls the input, and only when the next final character needs the output register.

module line_bracket_quote_checker_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] ch,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] error_code
);

	logic                  valid_s1;
	logic [7:0]            ch_s1;
	logic                  last_s1;
	logic                  adv_s1;
	lbqc_pkg::line_state_t state_q;
	lbqc_pkg::line_state_t state_nxt;
	lbqc_pkg::err_code_t   code_nxt;
	lbqc_pkg::err_code_t   code_q;
	logic                  out_valid_q;

	// an item leaves stage 1 unless it is a final character and the result slot is busy
	assign adv_s1   = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ch_s1   <= ch;
			last_s1 <= last;
		end
	end

	lbqc_step u_step (
		.cur  (state_q),
		.ch   (ch_s1),
		.last (last_s1),
		.nxt  (state_nxt),
		.code (code_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				state_q <= state_nxt;
			end
			if (adv_s1 && last_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			code_q <= code_nxt;
		end
	end

	assign out_valid  = out_valid_q;
	assign error_code = code_q;

`ifndef SYNTHESIS
	a_line_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && last_s1 |=> state_q == '0)
		else $error("tracking state not cleared after final character");

	a_result_from_line_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(adv_s1 && last_s1))
		else $error("result appeared without a final character");

	a_square_open_seen: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.square_open |-> state_q.square_seen_since)
		else $error("open square bracket without opener tracked");

	a_brace_open_seen: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.brace_open |-> state_q.brace_seen_since)
		else $error("open brace without opener tracked");
`endif

endmodule

/* verif/tb_line_bracket_quote_checker_core.sv */
// tb_line_bracket_quote_checker_core: self-checking testbench for the line bracket and
// quote checker, with a per-line error code predictor and an in-order scoreboard.
// Depends on lbqc_pkg and line_bracket_quote_checker_core.

module tb_line_bracket_quote_checker_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CHAR_COUNT  = 1950;
	localparam int CYCLE_LIMIT = 100000;
	localparam int HOLD_START  = 400;
	localparam int HOLD_CYCLES = 400;

	class line_code_scoreboard;
		bit sq_open, sq_seen, br_open, br_seen, dol_seen, q_par, prev_close_q;
		bit f_sq_open, f_sq_miss, f_br_open, f_br_miss, f_dol_miss, f_sign;
		bit [7:0] prev_ch;
		lbqc_pkg::err_code_t expected_codes[$];
		int errors;
		int lines_checked;
		int code_hits[8];

		function void clear_line();
			{sq_open, sq_seen, br_open, br_seen, dol_seen, q_par, prev_close_q} = '0;
			{f_sq_open, f_sq_miss, f_br_open, f_br_miss, f_dol_miss, f_sign} = '0;
			prev_ch = 8'h00;
		endfunction

		function bit sep_char(bit [7:0] c);
			case (c)
				lbqc_pkg::CH_COMMA, lbqc_pkg::CH_PLUS, lbqc_pkg::CH_MINUS,
				lbqc_pkg::CH_STAR, lbqc_pkg::CH_SLASH, lbqc_pkg::CH_LESS,
				lbqc_pkg::CH_GREATER, lbqc_pkg::CH_LPAREN, lbqc_pkg::CH_RPAREN,
				lbqc_pkg::CH_PIPE, lbqc_pkg::CH_AMP: return 1'b1;
				default: return 1'b0;
			endcase
		endfunction

		function lbqc_pkg::err_code_t line_verdict();
			if (f_sq_open || sq_open)      return lbqc_pkg::ERR_MISS_RSQ;
			else if (f_sq_miss)            return lbqc_pkg::ERR_MISS_LSQ;
			else if (f_br_open || br_open) return lbqc_pkg::ERR_MISS_RBRACE;
			else if (f_br_miss)            return lbqc_pkg::ERR_MISS_LBRACE;
			else if (f_dol_miss)           return lbqc_pkg::ERR_MISS_DOLLAR;
			else if (q_par)                return lbqc_pkg::ERR_ODD_QUOTES;
			else if (f_sign)               return lbqc_pkg::ERR_MISS_SIGN;
			else                           return lbqc_pkg::ERR_OK;
		endfunction

		// one accepted character; a final character queues the line's code
		function void note_char(bit [7:0] c, bit is_last);
			bit q;
			q = (c == lbqc_pkg::CH_QUOTE);
			if (!is_last && (prev_ch == lbqc_pkg::CH_RBRACE || prev_close_q) && !sep_char(c))
				f_sign = 1'b1;
			if (c == lbqc_pkg::CH_RSQUARE) begin
				sq_open = 1'b0;
				if (!sq_seen)
					f_sq_miss = 1'b1;
				sq_seen = 1'b0;
			end else if (c == lbqc_pkg::CH_LSQUARE) begin
				if (sq_open)
					f_sq_open = 1'b1;
				sq_open = 1'b1;
				sq_seen = 1'b1;
			end
			if (c == lbqc_pkg::CH_RBRACE) begin
				br_open = 1'b0;
				if (!br_seen)
					f_br_miss = 1'b1;
				br_seen = 1'b0;
				if (!dol_seen)
					f_dol_miss = 1'b1;
				dol_seen = 1'b0;
			end else if (c == lbqc_pkg::CH_LBRACE) begin
				if (br_open)
					f_br_open = 1'b1;
				br_open = 1'b1;
				br_seen = 1'b1;
			end else if (c == lbqc_pkg::CH_DOLLAR) begin
				dol_seen = 1'b1;
			end
			if (q)
				q_par = !q_par;
			prev_close_q = q && !q_par;
			prev_ch = c;
			if (is_last) begin
				expected_codes.push_back(line_verdict());
				clear_line();
			end
		endfunction

		function void check_code(logic [2:0] got);
			lbqc_pkg::err_code_t exp_code;
			if (expected_codes.size() == 0) begin
				$error("error_code %0d arrived with no line pending", got);
				errors++;
				return;
			end
			exp_code = expected_codes.pop_front();
			lines_checked++;
			code_hits[exp_code]++;
			if (got !== exp_code) begin
				$error("error_code mismatch: expected %0d actual %0d", exp_code, got);
				errors++;
			end
		endfunction

		function int pending();
			return expected_codes.size();
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] ch = 8'h00;
	logic       last = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [2:0] error_code;

	line_code_scoreboard sb;
	logic [7:0] line_buf[$];
	int chars_in = 0;
	int cycles = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	bit calm;

	line_bracket_quote_checker_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.ch(ch),
		.last(last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.error_code(error_code)
	);

	always #5 clk = ~clk;

	// stretch with no idling on either side
	assign calm = (chars_in >= 1000) && (chars_in < 1400);

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// receiver: random stalls plus one long hold-off while lines keep coming
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready = 1'b0;
		end else if (!hold_done && chars_in >= HOLD_START) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			out_ready = 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ready = 1'b0;
		end else if (calm) begin
			out_ready = 1'b1;
		end else begin
			out_ready = ($urandom_range(0, 99) >= 6);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_code(error_code);
	end

	// sends line_buf, last set on its final character
	task send_line();
		for (int i = 0; i < line_buf.size(); i++) begin
			if (!calm && $urandom_range(0, 99) < 6) begin
				repeat ($urandom_range(1, 3)) begin
					@(negedge clk);
					in_valid = 1'b0;
				end
			end
			@(negedge clk);
			in_valid = 1'b1;
			ch = line_buf[i];
			last = (i == line_buf.size() - 1);
			do @(posedge clk); while (!in_ready);
			sb.note_char(line_buf[i], i == line_buf.size() - 1);
			chars_in++;
		end
	endtask

	task send_text(input string s);
		line_buf = {};
		for (int i = 0; i < s.len(); i++)
			line_buf.push_back(s[i]);
		send_line();
	endtask

	function automatic logic [7:0] pick_sep();
		case ($urandom_range(0, 10))
			0: return lbqc_pkg::CH_COMMA;
			1: return lbqc_pkg::CH_PLUS;
			2: return lbqc_pkg::CH_MINUS;
			3: return lbqc_pkg::CH_STAR;
			4: return lbqc_pkg::CH_SLASH;
			5: return lbqc_pkg::CH_LESS;
			6: return lbqc_pkg::CH_GREATER;
			7: return lbqc_pkg::CH_LPAREN;
			8: return lbqc_pkg::CH_RPAREN;
			9: return lbqc_pkg::CH_PIPE;
			default: return lbqc_pkg::CH_AMP;
		endcase
	endfunction

	function automatic logic [7:0] pick_special();
		case ($urandom_range(0, 6))
			0: return lbqc_pkg::CH_LSQUARE;
			1: return lbqc_pkg::CH_RSQUARE;
			2: return lbqc_pkg::CH_LBRACE;
			3: return lbqc_pkg::CH_RBRACE;
			4: return lbqc_pkg::CH_DOLLAR;
			5: return lbqc_pkg::CH_QUOTE;
			default: return pick_sep();
		endcase
	endfunction

	function automatic logic [7:0] pick_letter();
		return 8'(8'h61 + $urandom_range(0, 25));
	endfunction

	task push_word();
		repeat ($urandom_range(0, 3))
			line_buf.push_back(pick_letter());
	endtask

	// mostly well-formed lines of tokens joined by separators, some damaged, some noise
	task build_line();
		int ntok;
		int pos;
		line_buf = {};
		if ($urandom_range(0, 99) < 25) begin
			repeat ($urandom_range(1, 12)) begin
				if ($urandom_range(0, 1))
					line_buf.push_back(pick_special());
				else
					line_buf.push_back(8'($urandom_range(0, 255)));
			end
			return;
		end
		ntok = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 4);
		for (int t = 0; t < ntok; t++) begin
			if (t > 0)
				line_buf.push_back(pick_sep());
			case ($urandom_range(0, 3))
				0: begin
					line_buf.push_back(pick_letter());
					push_word();
				end
				1: begin
					line_buf.push_back(lbqc_pkg::CH_LSQUARE);
					push_word();
					line_buf.push_back(lbqc_pkg::CH_RSQUARE);
				end
				2: begin
					line_buf.push_back(lbqc_pkg::CH_LBRACE);
					if ($urandom_range(0, 1)) begin
						line_buf.push_back(lbqc_pkg::CH_DOLLAR);
						push_word();
					end else begin
						push_word();
						line_buf.push_back(lbqc_pkg::CH_DOLLAR);
					end
					line_buf.push_back(lbqc_pkg::CH_RBRACE);
				end
				default: begin
					line_buf.push_back(lbqc_pkg::CH_QUOTE);
					push_word();
					line_buf.push_back(lbqc_pkg::CH_QUOTE);
				end
			endcase
		end
		if ($urandom_range(0, 99) < 30) begin
			pos = $urandom_range(0, line_buf.size() - 1);
			if ($urandom_range(0, 1))
				line_buf[pos] = pick_special();
			else
				line_buf.insert(pos, 8'($urandom_range(0, 255)));
		end
		if ($urandom_range(0, 99) < 15)
			repeat ($urandom_range(1, 2))
				line_buf.push_back(pick_letter());
	endtask

	initial begin
		sb = new;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// byte extremes, then each error code and the short-line cases
		line_buf = {8'h00};
		send_line();
		line_buf = {8'hFF};
		send_line();
		send_text("[]");
		send_text("[[");
		send_text("]");
		send_text("{$}");
		send_text("{{");
		send_text("}");
		send_text("{}");
		send_text("\"");
		send_text("\"\"ab");
		send_text("\"\"+b");

		while (chars_in < CHAR_COUNT) begin
			build_line();
			send_line();
		end
		@(negedge clk);
		in_valid = 1'b0;
		last = 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("%0d characters sent as %0d checked lines, with stalls on both sides",
			chars_in, sb.lines_checked);
		$display("lines per code 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
			sb.code_hits[0], sb.code_hits[1], sb.code_hits[2], sb.code_hits[3],
			sb.code_hits[4], sb.code_hits[5], sb.code_hits[6], sb.code_hits[7]);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
